### rtl/core/crc16fb_pkg.sv
// Package for the CRC-16 frame builder: constants and the byte-wide CRC update.
package crc16fb_pkg;

  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_TOP   = 16'h8000;
  localparam logic [15:0] CRC_INIT  = 16'h0000;
  localparam logic [7:0]  TAG_RESET = 8'h01;

  // CRC-16/XMODEM over one byte, MSB first, unrolled
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/crc16_frame_builder_top.sv
// CRC-16/XMODEM frame builder: tag header, payload pass-through, CRC trailer.
// An input byte passes through the single-item holding register, then the output register.
// Throughput: one output byte per cycle unless out_tready stalls; an item emits its
// byte, with the tag before it when it opens a frame and the CRC high and low
// bytes after it when it closes one; a new item is taken as the held one ends.
// Synchronous active-low reset: frame closed, CRC zero, frame_tag back to 1.
module crc16_frame_builder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,   // frame_tag
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [7:0] payload_byte
  input  logic       in_tlast,      // last_in
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // [7:0] out_byte
  output logic       out_tlast      // last_out
);

  typedef enum logic [1:0] {
    PH_TAG,
    PH_DATA,
    PH_HI,
    PH_LO
  } phase_t;

  logic [7:0]  frame_tag_r;
  logic [15:0] crc_acc_r, crc_acc_nxt;
  logic        inside_frame_r, inside_frame_nxt;

  // held input item
  logic        item_valid_r, item_valid_nxt;
  logic [7:0]  item_byte_r;
  logic        item_last_r;
  logic        started_r, started_nxt;   // item already emitted something
  logic        opened_r, opened_nxt;     // this item opened the frame
  phase_t      phase_r, phase_nxt;
  phase_t      phase_eff;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic        out_last_r, out_last_nxt;

  logic        out_load;
  logic        emit;
  logic        item_done;
  logic        in_xfer;

  assign out_load  = !out_valid_r || out_tready;
  assign emit      = item_valid_r && out_load;
  assign in_tready = !item_valid_r || (emit && item_done);
  assign in_xfer   = in_tvalid && in_tready;

  assign phase_eff = started_r ? phase_r : (inside_frame_r ? PH_DATA : PH_TAG);

  always_comb begin
    crc_acc_nxt      = crc_acc_r;
    inside_frame_nxt = inside_frame_r;
    started_nxt      = started_r;
    opened_nxt       = opened_r;
    phase_nxt        = phase_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_data_nxt     = out_data_r;
    out_last_nxt     = out_last_r;
    item_done        = 1'b0;

    if (emit) begin
      out_valid_nxt = 1'b1;
      started_nxt   = 1'b1;
      unique case (phase_eff)
        PH_TAG: begin
          out_data_nxt     = frame_tag_r;
          out_last_nxt     = 1'b0;
          crc_acc_nxt      = crc16fb_pkg::crc16_byte(crc16fb_pkg::CRC_INIT, frame_tag_r);
          inside_frame_nxt = 1'b1;
          opened_nxt       = 1'b1;
          phase_nxt        = PH_DATA;
        end
        PH_DATA: begin
          out_data_nxt = item_byte_r;
          out_last_nxt = 1'b0;
          crc_acc_nxt  = crc16fb_pkg::crc16_byte(crc_acc_r, item_byte_r);
          // last flag on the byte that opened the frame is ignored
          if (item_last_r && !opened_r) begin
            phase_nxt = PH_HI;
          end else begin
            item_done = 1'b1;
          end
        end
        PH_HI: begin
          out_data_nxt = crc_acc_r[15:8];
          out_last_nxt = 1'b0;
          phase_nxt    = PH_LO;
        end
        PH_LO: begin
          out_data_nxt     = crc_acc_r[7:0];
          out_last_nxt     = 1'b1;
          crc_acc_nxt      = crc16fb_pkg::CRC_INIT;
          inside_frame_nxt = 1'b0;
          item_done        = 1'b1;
        end
        default: begin
          item_done = 1'b1;
        end
      endcase
    end

    item_valid_nxt = item_valid_r && !(emit && item_done);
    if (in_xfer) begin
      item_valid_nxt = 1'b1;
      started_nxt    = 1'b0;
      opened_nxt     = 1'b0;
      phase_nxt      = PH_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_tag_r    <= crc16fb_pkg::TAG_RESET;
      crc_acc_r      <= crc16fb_pkg::CRC_INIT;
      inside_frame_r <= 1'b0;
      item_valid_r   <= 1'b0;
      started_r      <= 1'b0;
      opened_r       <= 1'b0;
      phase_r        <= PH_DATA;
      out_valid_r    <= 1'b0;
      out_data_r     <= 8'h00;
      out_last_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        frame_tag_r <= cfg_wr_data;
      end
      crc_acc_r      <= crc_acc_nxt;
      inside_frame_r <= inside_frame_nxt;
      item_valid_r   <= item_valid_nxt;
      started_r      <= started_nxt;
      opened_r       <= opened_nxt;
      phase_r        <= phase_nxt;
      out_valid_r    <= out_valid_nxt;
      out_data_r     <= out_data_nxt;
      out_last_r     <= out_last_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_byte_r <= in_tdata;
      item_last_r <= in_tlast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
